// ===== src/spiq_pkg.sv =====
// Shared types, codes and helpers for the stable priority insert queue.
`default_nettype none

package spiq_pkg;

  // Default number of stored entries
  localparam int unsigned CAPACITY_DEF = 32;

  // Field widths
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned NUM_LEVELS = 4;

  // Level range accepted on insert
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;

  // Operation codes
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_READOUT = 1'b1
  } spiq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_READ   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } spiq_status_t;

  // Controller states
  typedef enum logic {
    SPIQ_IDLE,
    SPIQ_READ
  } spiq_state_t;

  // One stored entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [LEVEL_W-1:0] level;
  } spiq_entry_t;

  // Clamp an insert level into 1..4
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] res;
    if (lvl < LEVEL_MIN) begin
      res = LEVEL_MIN;
    end else if (lvl > LEVEL_MAX) begin
      res = LEVEL_MAX;
    end else begin
      res = lvl;
    end
    return res;
  endfunction

  // Lowest set bit of a level mask
  function automatic logic [1:0] first_set(input logic [NUM_LEVELS-1:0] m);
    logic [1:0] res;
    if (m[0]) begin
      res = 2'd0;
    end else if (m[1]) begin
      res = 2'd1;
    end else if (m[2]) begin
      res = 2'd2;
    end else begin
      res = 2'd3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/spiq_store.sv =====
// Entry memory and link memory, both with registered reads.
`default_nettype none

module spiq_store #(
  parameter int unsigned CAPACITY = spiq_pkg::CAPACITY_DEF
) (
  input  wire                                   clk,
  // entry write
  input  wire                                   data_we,
  input  wire [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] data_waddr,
  input  wire spiq_pkg::spiq_entry_t            data_wdata,
  // link write
  input  wire                                   next_we,
  input  wire [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] next_waddr,
  input  wire [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] next_wdata,
  // shared read port
  input  wire                                   rd_en,
  input  wire [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  output spiq_pkg::spiq_entry_t                 rd_data,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_next
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  spiq_pkg::spiq_entry_t mem_data [CAPACITY];
  logic [IDX_W-1:0]      mem_next [CAPACITY];

  spiq_pkg::spiq_entry_t rd_data_r;
  logic [IDX_W-1:0]      rd_next_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (data_we) begin
      mem_data[data_waddr] <= data_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem_data[rd_addr];
    end
  end

  // link memory: slot of the following entry at the same level
  always_ff @(posedge clk) begin
    if (next_we) begin
      mem_next[next_waddr] <= next_wdata;
    end
    if (rd_en) begin
      rd_next_r <= mem_next[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_next = rd_next_r;

endmodule

`default_nettype wire

// ===== src/spiq_ctrl.sv =====
// Controller: per-level linked lists, insert handling, readout walk, output register.
`default_nettype none

module spiq_ctrl #(
  parameter int unsigned CAPACITY = spiq_pkg::CAPACITY_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_op,
  input  wire [15:0]                            in_arrival_tag,
  input  wire [2:0]                             in_level,
  // result channel
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [15:0]                           out_tag,
  output logic [2:0]                            out_level,
  output logic [1:0]                            out_status,
  output logic                                  out_last,
  // memory side
  output logic                                  data_we,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] data_waddr,
  output spiq_pkg::spiq_entry_t                 data_wdata,
  output logic                                  next_we,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] next_waddr,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] next_wdata,
  output logic                                  rd_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  input  wire spiq_pkg::spiq_entry_t            rd_data,
  input  wire [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_next
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned NL    = spiq_pkg::NUM_LEVELS;

  spiq_pkg::spiq_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [IDX_W-1:0] head_r [NL];
  logic [IDX_W-1:0] head_nxt [NL];
  logic [IDX_W-1:0] tail_r [NL];
  logic [IDX_W-1:0] tail_nxt [NL];
  logic [NL-1:0]    nonempty_r, nonempty_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_tag_r, out_tag_nxt;
  logic [2:0]       out_level_r, out_level_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free;
  logic             in_xfer;
  logic             is_full;
  logic             rd_done;
  logic [2:0]       lvl_sat;
  logic [1:0]       lvl_idx;
  logic [1:0]       first_lvl;
  logic [1:0]       cur_idx;
  logic [1:0]       next_lvl;
  logic [NL-1:0]    above_mask;
  logic [IDX_W-1:0] next_ptr;
  logic [IDX_W-1:0] slot;

  // handshake and shared terms
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == spiq_pkg::SPIQ_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;
  assign is_full  = (count_r >= CNT_W'(CAPACITY));
  assign rd_done  = (remain_r == CNT_W'(1));
  assign slot     = count_r[IDX_W-1:0];

  // insert level and list selection
  assign lvl_sat   = spiq_pkg::sat_level(in_level);
  assign lvl_idx   = 2'(lvl_sat - 3'd1);
  assign first_lvl = spiq_pkg::first_set(nonempty_r);

  // readout walk: follow the link, or jump to the next non-empty level at a tail
  assign cur_idx    = 2'(rd_data.level - 3'd1);
  assign above_mask = NL'(4'b1110 << cur_idx);
  assign next_lvl   = spiq_pkg::first_set(nonempty_r & above_mask);
  assign next_ptr   = (rd_ptr_r == tail_r[cur_idx]) ? head_r[next_lvl] : rd_next;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spiq_pkg::SPIQ_IDLE: begin
        if (in_xfer && (in_op == spiq_pkg::OP_READOUT) && (count_r != '0)) begin
          state_nxt = spiq_pkg::SPIQ_READ;
        end
      end
      spiq_pkg::SPIQ_READ: begin
        if (out_free && rd_done) begin
          state_nxt = spiq_pkg::SPIQ_IDLE;
        end
      end
      default: state_nxt = spiq_pkg::SPIQ_IDLE;
    endcase
  end

  // datapath, memory commands and output register
  always_comb begin
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    rd_ptr_nxt     = rd_ptr_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nonempty_nxt   = nonempty_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_tag_nxt    = out_tag_r;
    out_level_nxt  = out_level_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    data_we        = 1'b0;
    data_waddr     = slot;
    data_wdata     = '{tag: in_arrival_tag, level: lvl_sat};
    next_we        = 1'b0;
    next_waddr     = tail_r[lvl_idx];
    next_wdata     = slot;
    rd_en          = 1'b0;
    rd_addr        = head_r[first_lvl];

    case (state_r)
      spiq_pkg::SPIQ_IDLE: begin
        if (in_xfer) begin
          out_tag_nxt   = '0;
          out_level_nxt = '0;
          out_last_nxt  = 1'b1;
          if (in_op == spiq_pkg::OP_INSERT) begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              out_status_nxt = spiq_pkg::ST_FULL;
            end else begin
              // append to the tail of this level's list
              out_status_nxt = spiq_pkg::ST_ACCEPT;
              data_we        = 1'b1;
              if (nonempty_r[lvl_idx]) begin
                next_we = 1'b1;
              end else begin
                head_nxt[lvl_idx] = slot;
              end
              tail_nxt[lvl_idx]     = slot;
              nonempty_nxt[lvl_idx] = 1'b1;
              count_nxt             = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = spiq_pkg::ST_EMPTY;
          end else begin
            // start the walk at the most urgent non-empty level
            rd_en      = 1'b1;
            rd_ptr_nxt = head_r[first_lvl];
            remain_nxt = count_r;
          end
        end
      end
      spiq_pkg::SPIQ_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_tag_nxt    = rd_data.tag;
          out_level_nxt  = rd_data.level;
          out_status_nxt = spiq_pkg::ST_READ;
          out_last_nxt   = rd_done;
          if (!rd_done) begin
            rd_en      = 1'b1;
            rd_addr    = next_ptr;
            rd_ptr_nxt = next_ptr;
            remain_nxt = remain_r - CNT_W'(1);
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spiq_pkg::SPIQ_IDLE;
      count_r     <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    remain_r     <= remain_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    out_tag_r    <= out_tag_nxt;
    out_level_r  <= out_level_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_tag    = out_tag_r;
  assign out_level  = out_level_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== src/stable_priority_insert_queue.sv =====
// Top level of the stable priority insert queue.
// Usage:
//   Input channel (in_valid/in_ready): in_op selects insert (0) or readout (1);
//   an insert carries in_arrival_tag and in_level (0 is taken as 1, 5..7 as 4).
//   Result channel (out_valid/out_ready): out_tag, out_level, out_status, out_last.
//   An insert answers with one result (accepted, or dropped when CAPACITY entries
//   are held); a readout returns every entry by level, oldest first within a
//   level, marking the final one, or one empty result when nothing is stored.
// Timing:
//   An insert or an empty readout gives its result the cycle after the
//   transfer, and the next item can transfer at the same edge as that result
//   is taken. A readout of N entries gives its first result through the memory
//   read register and then the output register, then one result per cycle while
//   out_ready stays high; the walk through the entry and link memories (one read
//   port) sets this pace, and the next item can transfer as its last is taken.
// Reset: rst_n (synchronous, active low) empties the queue; memory contents and
//   list pointers are not cleared, only the count, per-level list flags, state and out_valid.
// Stall: while out_ready is low a valid result is held, the walk pauses and no
//   item is taken.
`default_nettype none

module stable_priority_insert_queue #(
  parameter int unsigned CAPACITY = spiq_pkg::CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_op,
  input  wire [15:0] in_arrival_tag,
  input  wire [2:0]  in_level,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [15:0] out_tag,
  output logic [2:0] out_level,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  data_we;
  logic [IDX_W-1:0]      data_waddr;
  spiq_pkg::spiq_entry_t data_wdata;
  logic                  next_we;
  logic [IDX_W-1:0]      next_waddr;
  logic [IDX_W-1:0]      next_wdata;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  spiq_pkg::spiq_entry_t rd_data;
  logic [IDX_W-1:0]      rd_next;

  spiq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_arrival_tag (in_arrival_tag),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tag        (out_tag),
    .out_level      (out_level),
    .out_status     (out_status),
    .out_last       (out_last),
    .data_we        (data_we),
    .data_waddr     (data_waddr),
    .data_wdata     (data_wdata),
    .next_we        (next_we),
    .next_waddr     (next_waddr),
    .next_wdata     (next_wdata),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .rd_next        (rd_next)
  );

  spiq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk        (clk),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_next    (rd_next)
  );

  // inserts and readout walks never overlap
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(data_we && rd_en))
    else $error("memory write during readout walk");

  // a link is only written together with the entry it points to
  a_link_with_entry: assert property (@(posedge clk) disable iff (!rst_n)
    next_we |-> (data_we && (next_wdata == data_waddr)))
    else $error("link write without matching entry write");

  // every non-readout result ends its item
  a_single_marked_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != spiq_pkg::ST_READ)) |-> out_last)
    else $error("status result not marked last");

  // no item is taken in the cycle after a memory read is issued
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> !in_ready)
    else $error("input taken while read data pending");

endmodule

`default_nettype wire
